// ===== rtl/obd2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II poll and reply decoder package
// Shared types, codes and small helper functions.
// ----------------------------------------------------------------------------
package obd2_pkg;

  localparam int unsigned CanIdW    = 11;
  localparam int unsigned TickW     = 16;
  localparam int unsigned RpmW      = 14;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned CoolantW  = 9;
  localparam int unsigned LoadW     = 7;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [CanIdW-1:0] ReqIdReset   = 11'h7DF;
  localparam logic [TickW-1:0]  TimeoutReset = 16'd2500;
  localparam logic [TickW-1:0]  TickMax      = 16'hFFFF;

  localparam logic [7:0] ReplyIdHigh8 = 8'hFD;
  localparam logic [7:0] ReplyMode    = 8'h41;
  localparam logic [7:0] PollCount    = 8'h02;
  localparam logic [7:0] PollMode     = 8'h01;
  localparam logic [39:0] PollPad     = 40'h55_5555_5555;

  localparam logic [7:0] PidRpm     = 8'h0C;
  localparam logic [7:0] PidSpeed   = 8'h0D;
  localparam logic [7:0] PidCoolant = 8'h05;
  localparam logic [7:0] PidLoad    = 8'h04;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_POLL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_RPM     = 3'd1,
    STAT_SPEED   = 3'd2,
    STAT_COOLANT = 3'd3,
    STAT_LOAD    = 3'd4,
    STAT_OTHER   = 3'd5
  } status_t;

  typedef enum logic [PaddrW-1:0] {
    REG_REQ_ID  = 3'd0,
    REG_TIMEOUT = 3'd4
  } reg_addr_t;

  typedef struct packed {
    logic [CanIdW-1:0] request_can_id;
    logic [TickW-1:0]  link_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 accepted;
    status_t              status;
    logic [RpmW-1:0]      rpm;
    logic [SpeedW-1:0]    speed;
    logic [CoolantW-1:0]  coolant;
    logic [LoadW-1:0]     load;
  } dec_t;

  function automatic logic [7:0] poll_pid(input logic [1:0] phase);
    logic [7:0] pid;
    case (phase)
      2'd0:    pid = PidRpm;
      2'd1:    pid = PidSpeed;
      2'd2:    pid = PidCoolant;
      default: pid = PidLoad;
    endcase
    return pid;
  endfunction

  // Exact floor(a * 100 / 255) for any byte.
  function automatic logic [LoadW-1:0] load_pct(input logic [7:0] a);
    logic [14:0] prod;
    logic [15:0] sum;
    prod = 15'(a) * 15'd100;
    sum  = 16'(prod) + 16'(prod[14:8]) + 16'd1;
    return sum[14:8];
  endfunction

endpackage

// ===== rtl/obd2_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II configuration registers
// APB-style register file holding the poll identifier and link timeout.
// ----------------------------------------------------------------------------
module obd2_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [obd2_pkg::PaddrW-1:0]      paddr,
  input  logic [obd2_pkg::PdataW-1:0]      pwdata,
  output logic [obd2_pkg::PdataW-1:0]      prdata,
  output logic                             pready,
  output obd2_pkg::cfg_t                   cfg
);

  logic [obd2_pkg::CanIdW-1:0] req_id_r;
  logic [obd2_pkg::TickW-1:0]  timeout_r;
  logic                        wr_en;
  logic                        sel_timeout;

  assign pready      = 1'b1;
  assign wr_en       = psel & penable & pwrite;
  assign sel_timeout = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_id_r  <= obd2_pkg::ReqIdReset;
      timeout_r <= obd2_pkg::TimeoutReset;
    end else if (wr_en) begin
      if (sel_timeout) begin
        timeout_r <= pwdata[obd2_pkg::TickW-1:0];
      end else begin
        req_id_r <= pwdata[obd2_pkg::CanIdW-1:0];
      end
    end
  end

  always_comb begin
    if (sel_timeout) begin
      prdata = obd2_pkg::PdataW'(timeout_r);
    end else begin
      prdata = obd2_pkg::PdataW'(req_id_r);
    end
  end

  assign cfg.request_can_id     = req_id_r;
  assign cfg.link_timeout_ticks = timeout_r;

endmodule

// ===== rtl/obd2_reply_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II reply decoder
// Qualifies a received frame as a mode 01 reply and decodes its PID.
// ----------------------------------------------------------------------------
module obd2_reply_decode (
  input  logic [1:0]                   kind,
  input  logic [obd2_pkg::CanIdW-1:0]  frame_id,
  input  logic [3:0]                   frame_length,
  input  logic [63:0]                  frame_bytes,
  output obd2_pkg::dec_t               dec
);

  logic [7:0] byte0;
  logic [7:0] mode;
  logic [7:0] pid;
  logic [7:0] a;
  logic [7:0] b;
  logic       has_one;
  logic       has_two;

  assign byte0 = frame_bytes[63:56];
  assign mode  = frame_bytes[55:48];
  assign pid   = frame_bytes[47:40];
  assign a     = frame_bytes[39:32];
  assign b     = frame_bytes[31:24];

  // Length byte counts the mode and PID bytes as well as the data bytes.
  assign has_one = (byte0 >= 8'd3);
  assign has_two = (byte0 >= 8'd4);

  always_comb begin
    dec.accepted = (kind == obd2_pkg::KIND_FRAME) &&
                   (frame_id[10:3] == obd2_pkg::ReplyIdHigh8) &&
                   (frame_length >= 4'd3) &&
                   (mode == obd2_pkg::ReplyMode);
    dec.rpm      = {a, b[7:2]};
    dec.speed    = a;
    dec.coolant  = {1'b0, a} - 9'd40;
    dec.load     = obd2_pkg::load_pct(a);
    dec.status   = obd2_pkg::STAT_NONE;
    if (dec.accepted) begin
      dec.status = obd2_pkg::STAT_OTHER;
      if (has_one) begin
        case (pid)
          obd2_pkg::PidRpm: begin
            if (has_two) begin
              dec.status = obd2_pkg::STAT_RPM;
            end
          end
          obd2_pkg::PidSpeed:   dec.status = obd2_pkg::STAT_SPEED;
          obd2_pkg::PidCoolant: dec.status = obd2_pkg::STAT_COOLANT;
          obd2_pkg::PidLoad:    dec.status = obd2_pkg::STAT_LOAD;
          default:              dec.status = obd2_pkg::STAT_OTHER;
        endcase
      end
    end
  end

endmodule

// ===== rtl/obd2_poll_and_reply_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II poll and reply decoder core
// Generates rotating mode 01 poll frames, decodes replies and tracks link age.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in_       request    in_valid / in_stall   kind, frame id, length, bytes
// out_      result     out_valid / out_stall poll frame, status, stored values
// cfg       APB        psel/penable/pready   request id, link timeout
//
// An accepted request sits in the input register, is decoded combinationally and
// written into the result register unless a stalled result is held there. One
// request per cycle is sustained while out_stall is low. Reset is synchronous,
// clears control state and stored values, and loads the configuration defaults. A
// stalled result holds while the input register still takes one more request.
// ----------------------------------------------------------------------------
module obd2_poll_and_reply_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [10:0]                       in_frame_id,
  input  logic [3:0]                        in_frame_length,
  input  logic [63:0]                       in_frame_bytes,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_poll_valid,
  output logic [10:0]                       out_poll_id,
  output logic [63:0]                       out_poll_bytes,
  output logic [2:0]                        out_decode_status,
  output logic [13:0]                       out_engine_rpm,
  output logic [7:0]                        out_vehicle_speed,
  output logic signed [8:0]                 out_coolant_temp,
  output logic [6:0]                        out_engine_load,
  output logic                              out_link_up,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obd2_pkg::PaddrW-1:0]       paddr,
  input  logic [obd2_pkg::PdataW-1:0]       pwdata,
  output logic [obd2_pkg::PdataW-1:0]       prdata,
  output logic                              pready
);

  obd2_pkg::cfg_t cfg;
  obd2_pkg::dec_t dec;

  logic        in_valid_r;
  logic [1:0]  kind_r;
  logic [10:0] frame_id_r;
  logic [3:0]  frame_length_r;
  logic [63:0] frame_bytes_r;

  logic [1:0]                    phase_r, phase_nxt;
  logic                          seen_r, seen_nxt;
  logic [obd2_pkg::TickW-1:0]    ticks_r, ticks_nxt;
  logic [obd2_pkg::RpmW-1:0]     rpm_r, rpm_nxt;
  logic [obd2_pkg::SpeedW-1:0]   speed_r, speed_nxt;
  logic [obd2_pkg::CoolantW-1:0] coolant_r, coolant_nxt;
  logic [obd2_pkg::LoadW-1:0]    load_r, load_nxt;

  logic        out_valid_r;
  logic        poll_valid_r, poll_valid_nxt;
  logic [10:0] poll_id_r, poll_id_nxt;
  logic [63:0] poll_bytes_r, poll_bytes_nxt;
  logic [2:0]  status_r;
  logic        link_up_r, link_up_nxt;

  logic advance;
  logic in_take;

  assign advance  = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  obd2_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  obd2_reply_decode u_dec (
    .kind         (kind_r),
    .frame_id     (frame_id_r),
    .frame_length (frame_length_r),
    .frame_bytes  (frame_bytes_r),
    .dec          (dec)
  );

  always_comb begin
    phase_nxt      = phase_r;
    seen_nxt       = seen_r;
    ticks_nxt      = ticks_r;
    rpm_nxt        = rpm_r;
    speed_nxt      = speed_r;
    coolant_nxt    = coolant_r;
    load_nxt       = load_r;
    poll_valid_nxt = 1'b0;
    poll_id_nxt    = '0;
    poll_bytes_nxt = '0;
    case (kind_r)
      obd2_pkg::KIND_TICK: begin
        if (ticks_r != obd2_pkg::TickMax) begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
      obd2_pkg::KIND_POLL: begin
        poll_valid_nxt = 1'b1;
        poll_id_nxt    = cfg.request_can_id;
        poll_bytes_nxt = {obd2_pkg::PollCount, obd2_pkg::PollMode,
                          obd2_pkg::poll_pid(phase_r), obd2_pkg::PollPad};
        phase_nxt      = phase_r + 2'd1;
      end
      default: begin
      end
    endcase
    if (dec.accepted) begin
      seen_nxt  = 1'b1;
      ticks_nxt = '0;
    end
    case (dec.status)
      obd2_pkg::STAT_RPM:     rpm_nxt     = dec.rpm;
      obd2_pkg::STAT_SPEED:   speed_nxt   = dec.speed;
      obd2_pkg::STAT_COOLANT: coolant_nxt = dec.coolant;
      obd2_pkg::STAT_LOAD:    load_nxt    = dec.load;
      default: begin
      end
    endcase
    link_up_nxt = seen_nxt & (ticks_nxt < cfg.link_timeout_ticks);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      seen_r      <= 1'b0;
      ticks_r     <= '0;
      rpm_r       <= '0;
      speed_r     <= '0;
      coolant_r   <= '0;
      load_r      <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        seen_r      <= seen_nxt;
        ticks_r     <= ticks_nxt;
        rpm_r       <= rpm_nxt;
        speed_r     <= speed_nxt;
        coolant_r   <= coolant_nxt;
        load_r      <= load_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r         <= in_kind;
      frame_id_r     <= in_frame_id;
      frame_length_r <= in_frame_length;
      frame_bytes_r  <= in_frame_bytes;
    end
    if (advance) begin
      poll_valid_r <= poll_valid_nxt;
      poll_id_r    <= poll_id_nxt;
      poll_bytes_r <= poll_bytes_nxt;
      status_r     <= dec.status;
      link_up_r    <= link_up_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_poll_valid    = poll_valid_r;
  assign out_poll_id       = poll_id_r;
  assign out_poll_bytes    = poll_bytes_r;
  assign out_decode_status = status_r;
  assign out_engine_rpm    = rpm_r;
  assign out_vehicle_speed = speed_r;
  assign out_coolant_temp  = $signed(coolant_r);
  assign out_engine_load   = load_r;
  assign out_link_up       = link_up_r;

endmodule

// ===== rtl/obd2_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II decoder port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
module obd2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_poll_valid,
  input logic [10:0] out_poll_id,
  input logic [63:0] out_poll_bytes,
  input logic [2:0]  out_decode_status,
  input logic [6:0]  out_engine_load
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_poll_bytes) &&
      $stable(out_decode_status))
    else $error("stalled result changed");

  a_no_poll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_poll_valid |-> out_poll_id == 11'd0 && out_poll_bytes == 64'd0)
    else $error("poll fields set without poll frame");

  a_poll_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_poll_valid |-> out_decode_status == obd2_pkg::STAT_NONE &&
      out_poll_bytes[63:48] == 16'h0201 && out_poll_bytes[39:0] == obd2_pkg::PollPad)
    else $error("malformed poll frame");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_engine_load <= 7'd100)
    else $error("engine load above 100");

endmodule

bind obd2_poll_and_reply_decoder_core obd2_checker u_obd2_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_poll_valid    (out_poll_valid),
  .out_poll_id       (out_poll_id),
  .out_poll_bytes    (out_poll_bytes),
  .out_decode_status (out_decode_status),
  .out_engine_load   (out_engine_load)
);
